// ===== design/tga_rle_pixel_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core assertion macros
// concurrent checks clocked on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define TGARD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tgard same-cycle check failed");

// next-cycle implication
`define TGARD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tgard next-cycle check failed");

`endif

// ===== design/tgard_pkg.sv =====
// ----------------------------------------------------------------------------
// tgard_pkg
// types and constants shared by the run-length pixel decoder modules
// ----------------------------------------------------------------------------
package tgard_pkg;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // input op codes
   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // packet header layout
   localparam int HDR_REPEAT_BIT = 7;

   // pixel format
   localparam logic [2:0] PIXEL_BYTES_FOUR  = 3'd4;
   localparam logic [2:0] PIXEL_BYTES_RESET = 3'd4;
   localparam logic [7:0] ALPHA_OPAQUE      = 8'hFF;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PIXEL_BYTES  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       last_pixel;
      logic       status;
   } rsp_payload_type;

   // classified work for the back part
   typedef struct packed {
      logic        drop;
      logic        four_byte;
      logic        last;
      logic [31:0] pixel;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

// ===== design/tgard_front.sv =====
// ----------------------------------------------------------------------------
// tgard_front
// packet parser: assembles pixels, tracks runs and the image pixel count,
// and turns each accepted byte or drain tick into at most one command
// ----------------------------------------------------------------------------
module tgard_front
   import tgard_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req_item,
   input  logic [2:0]      pixel_bytes,
   input  logic [31:0]     image_total,
   output logic            cmd_valid,
   output cmd_type         cmd
);

   logic        expect_header_ff, expect_header_in;
   logic        is_repeat_ff, is_repeat_in;
   logic [7:0]  packet_remaining_ff, packet_remaining_in;
   logic [1:0]  byte_position_ff, byte_position_in;
   logic [31:0] pixel_assembly_ff, pixel_assembly_in;
   logic [7:0]  repeats_pending_ff, repeats_pending_in;
   logic [31:0] pixels_emitted_ff, pixels_emitted_in;

   logic        four_byte;
   logic        last_hit;
   logic        pixel_done;
   logic [1:0]  position_next;
   logic [31:0] assembly_next;
   logic [7:0]  remaining_dec;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff    <= 1'b1;
         is_repeat_ff        <= 1'b0;
         packet_remaining_ff <= '0;
         byte_position_ff    <= '0;
         pixel_assembly_ff   <= '0;
         repeats_pending_ff  <= '0;
         pixels_emitted_ff   <= '0;
      end else begin
         expect_header_ff    <= expect_header_in;
         is_repeat_ff        <= is_repeat_in;
         packet_remaining_ff <= packet_remaining_in;
         byte_position_ff    <= byte_position_in;
         pixel_assembly_ff   <= pixel_assembly_in;
         repeats_pending_ff  <= repeats_pending_in;
         pixels_emitted_ff   <= pixels_emitted_in;
      end
   end

   // pixel size and end-of-image compare
   assign four_byte = (pixel_bytes == PIXEL_BYTES_FOUR);
   assign last_hit  = ({1'b0, pixels_emitted_ff} + 33'd1) >= {1'b0, image_total};

   // byte placement into the pixel word
   assign position_next = byte_position_ff + 2'd1;
   assign assembly_next = (byte_position_ff == 2'd0) ? {24'b0, req_item.data_byte}
      : (pixel_assembly_ff | ({24'b0, req_item.data_byte} << {byte_position_ff, 3'b000}));
   assign pixel_done    = (position_next == 2'd0) || (!four_byte && position_next == 2'd3);
   assign remaining_dec = (packet_remaining_ff != 8'd0) ? packet_remaining_ff - 8'd1
                                                        : packet_remaining_ff;

   // classify the accepted item
   always_comb begin
      expect_header_in    = expect_header_ff;
      is_repeat_in        = is_repeat_ff;
      packet_remaining_in = packet_remaining_ff;
      byte_position_in    = byte_position_ff;
      pixel_assembly_in   = pixel_assembly_ff;
      repeats_pending_in  = repeats_pending_ff;
      pixels_emitted_in   = pixels_emitted_ff;
      cmd_valid           = 1'b0;
      cmd.drop            = 1'b0;
      cmd.four_byte       = four_byte;
      cmd.last            = last_hit;
      cmd.pixel           = pixel_assembly_ff;

      if (accept) begin
         if (req_item.op == OP_DRAIN) begin
            // one copy of the pending run pixel
            if (repeats_pending_ff != 8'd0) begin
               cmd_valid          = 1'b1;
               pixels_emitted_in  = last_hit ? 32'd0 : pixels_emitted_ff + 32'd1;
               repeats_pending_in = last_hit ? 8'd0 : repeats_pending_ff - 8'd1;
            end
         end else if (repeats_pending_ff != 8'd0) begin
            // byte while a run is still pending
            cmd_valid = 1'b1;
            cmd.drop  = 1'b1;
         end else if (expect_header_ff) begin
            is_repeat_in        = req_item.data_byte[HDR_REPEAT_BIT];
            packet_remaining_in = {1'b0, req_item.data_byte[HDR_REPEAT_BIT-1:0]} + 8'd1;
            byte_position_in    = 2'd0;
            expect_header_in    = 1'b0;
         end else begin
            pixel_assembly_in = assembly_next;
            byte_position_in  = pixel_done ? 2'd0 : position_next;
            if (pixel_done) begin
               if (is_repeat_ff) begin
                  // run pixel complete, copies go out on drain ticks
                  repeats_pending_in  = packet_remaining_ff;
                  packet_remaining_in = 8'd0;
                  expect_header_in    = 1'b1;
               end else begin
                  cmd_valid           = 1'b1;
                  cmd.pixel           = assembly_next;
                  pixels_emitted_in   = last_hit ? 32'd0 : pixels_emitted_ff + 32'd1;
                  packet_remaining_in = remaining_dec;
                  if (remaining_dec == 8'd0) begin
                     expect_header_in = 1'b1;
                  end
               end
            end
         end
      end
   end

endmodule

// ===== design/tgard_queue.sv =====
// ----------------------------------------------------------------------------
// tgard_queue
// small command queue that decouples the parser from the output side
// ----------------------------------------------------------------------------
module tgard_queue
   import tgard_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  cmd_type          wr_data,
   input  logic             rd_en,
   output cmd_type          rd_data,
   output queue_status_type status
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_write;
   logic                do_read;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_write         = wr_en && !status.full;
   assign do_read          = rd_en && status.not_empty;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_write ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_read ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_write && !do_read) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_read && !do_write) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = entry_ff[rd_ptr_ff];

endmodule

// ===== design/tgard_back.sv =====
// ----------------------------------------------------------------------------
// tgard_back
// output stage: formats queued commands into result items and holds the
// oldest one until it is taken
// ----------------------------------------------------------------------------
module tgard_back
   import tgard_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  cmd_type         cmd,
   output logic            cmd_take,
   input  logic            pop,
   output logic            empty,
   output rsp_payload_type rsp_item
);

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff, out_item_in;

   // load when the output register is free or being drained
   assign cmd_take     = cmd_valid && (!out_valid_ff || pop);
   assign out_valid_in = cmd_take || (out_valid_ff && !pop);

   // result formatting
   always_comb begin
      out_item_in = out_item_ff;
      if (cmd_take) begin
         if (cmd.drop) begin
            out_item_in        = '0;
            out_item_in.status = 1'b1;
         end else begin
            out_item_in.blue       = cmd.pixel[7:0];
            out_item_in.green      = cmd.pixel[15:8];
            out_item_in.red        = cmd.pixel[23:16];
            out_item_in.alpha      = cmd.four_byte ? cmd.pixel[31:24] : ALPHA_OPAQUE;
            out_item_in.last_pixel = cmd.last;
            out_item_in.status     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_item = out_item_ff;

endmodule

// ===== design/tga_rle_pixel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// run-length pixel stream decoder: one stream byte or drain tick per transfer
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while full is low, byte or drain tick, with no
// gaps required. The parser decides each item in the cycle it is accepted and
// writes at most one command into a four-entry queue; the output register loads
// the oldest queued command when it is free or being popped, and the result
// shows on rsp_item from that register. full rises only when the queue and the
// output register are all occupied and pop stays low. Configuration writes
// take effect on the next edge; the image size product is registered with them.
`include "tga_rle_pixel_decoder_core_assert.svh"

module tga_rle_pixel_decoder_core
   import tgard_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  req_payload_type req_item,
   output logic            empty,
   input  logic            pop,
   output rsp_payload_type rsp_item,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata
);

   logic [2:0]       pixel_bytes_ff, pixel_bytes_in;
   logic [15:0]      image_width_ff, image_width_in;
   logic [15:0]      image_height_ff, image_height_in;
   logic [31:0]      image_total_ff, image_total_in;
   logic             accept;
   logic             front_valid;
   cmd_type          front_cmd;
   cmd_type          queue_cmd;
   queue_status_type queue_status;
   logic             queue_take;

   // configuration registers
   always_comb begin
      pixel_bytes_in  = pixel_bytes_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PIXEL_BYTES:  pixel_bytes_in  = csr_wdata[2:0];
            CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
            default: ;
         endcase
      end
      image_total_in = image_width_in * image_height_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff  <= PIXEL_BYTES_RESET;
         image_width_ff  <= 16'd1;
         image_height_ff <= 16'd1;
         image_total_ff  <= 32'd1;
      end else begin
         pixel_bytes_ff  <= pixel_bytes_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         image_total_ff  <= image_total_in;
      end
   end

   // input transfer
   assign full   = queue_status.full;
   assign accept = push && !full;

   tgard_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_item    (req_item),
      .pixel_bytes (pixel_bytes_ff),
      .image_total (image_total_ff),
      .cmd_valid   (front_valid),
      .cmd         (front_cmd)
   );

   tgard_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_cmd),
      .rd_en   (queue_take),
      .rd_data (queue_cmd),
      .status  (queue_status)
   );

   tgard_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_status.not_empty),
      .cmd       (queue_cmd),
      .cmd_take  (queue_take),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item)
   );

   // checks
   `TGARD_ASSERT_SAME(a_no_write_when_full, front_valid, !queue_status.full)
   `TGARD_ASSERT_NEXT(a_queue_feeds_output, empty && queue_status.not_empty, !empty)
   `TGARD_ASSERT_SAME(a_drop_is_blank, !empty && rsp_item.status,
      rsp_item.last_pixel == 1'b0 && rsp_item.alpha == 8'd0 && rsp_item.blue == 8'd0)

endmodule
